// ----- rtl/core/efws_pkg.sv -----
// Shared types and constants for the earliest-free-worker scheduler.
// Used by efws_sel and earliest_free_worker_scheduler_top; no dependencies.
`default_nettype none
package efws_pkg;

  localparam int MaxWorkers = 64;
  localparam int AddrW      = (MaxWorkers > 1) ? $clog2(MaxWorkers) : 1;
  localparam int ChildW     = $clog2(2 * MaxWorkers + 1);
  localparam int WorkerW    = AddrW;
  localparam int TimeW      = 48;
  localparam int DurW       = 32;
  localparam int WorkerIdW  = 6;
  localparam int CfgW       = 7;

  // Free time sits above the worker number, so comparing the packed value
  // orders by time first and breaks ties towards the lower worker.
  typedef struct packed {
    logic [TimeW-1:0]   free_time;
    logic [WorkerW-1:0] worker;
  } key_t;

  typedef enum logic [1:0] {
    PickElem,
    PickLeft,
    PickRight
  } pick_e;

  typedef struct packed {
    pick_e pick;
    key_t  best;
  } sel_t;

endpackage
`default_nettype wire

// ----- rtl/core/efws_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module efws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic      [Width-1:0]                         rdata_a_o,
  output logic      [Width-1:0]                         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/efws_sel.sv -----
// Shared compare unit: picks the smallest of the moving element and its children.
// Depends on efws_pkg.
`default_nettype none
module efws_sel (
  input  wire logic          right_ok_i,
  input  efws_pkg::key_t     elem_i,
  input  efws_pkg::key_t     left_i,
  input  efws_pkg::key_t     right_i,
  output efws_pkg::sel_t     sel_o
);

  logic l_lt_e;
  logic r_lt_e;
  logic r_lt_l;

  assign l_lt_e = left_i < elem_i;
  assign r_lt_e = right_i < elem_i;
  assign r_lt_l = right_i < left_i;

  always_comb begin
    sel_o.pick = efws_pkg::PickElem;
    sel_o.best = elem_i;
    if (l_lt_e) begin
      if (right_ok_i && r_lt_l) begin
        sel_o.pick = efws_pkg::PickRight;
        sel_o.best = right_i;
      end else begin
        sel_o.pick = efws_pkg::PickLeft;
        sel_o.best = left_i;
      end
    end else if (right_ok_i && r_lt_e) begin
      sel_o.pick = efws_pkg::PickRight;
      sel_o.best = right_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/earliest_free_worker_scheduler_top.sv -----
// Earliest-free-worker scheduler: binary min-heap of workers keyed by free time.
// The result transaction is registered onto done_o when start is taken.
// busy stays high while the element is sifted down, through a read and a compare state per
// heap level compared, plus a read state when the element settles in a leaf; start is
// taken only while busy is low. The receiver cannot stall.
// Reset (or a worker-count write) refills the heap at once. Uses efws_pkg, efws_ram, efws_sel.
`default_nettype none
module earliest_free_worker_scheduler_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [efws_pkg::DurW-1:0]       job_duration_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [efws_pkg::CfgW-1:0]       cfg_wdata_i,
  output logic                                 done_o,
  output logic      [efws_pkg::WorkerIdW-1:0]  worker_id_o,
  output logic      [efws_pkg::TimeW-1:0]      start_time_o
);

  // Sequencer codes. The moving element is carried down in elem_q; each level
  // has a read state for both children and a compare state that writes the winner.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [efws_pkg::AddrW-1:0]      pos_q, pos_d;
  efws_pkg::key_t                  elem_q, elem_d;
  efws_pkg::key_t                  root_q;
  logic [efws_pkg::CfgW-1:0]       active_workers_q;
  logic [efws_pkg::MaxWorkers-1:0] valid_q;
  logic                            left_valid_q;
  logic                            right_valid_q;
  logic                            done_q;
  logic [efws_pkg::WorkerIdW-1:0]  worker_id_q;
  logic [efws_pkg::TimeW-1:0]      start_time_q;

  logic [efws_pkg::ChildW-1:0]     heap_count;
  logic [efws_pkg::ChildW-1:0]     left_idx;
  logic [efws_pkg::ChildW-1:0]     right_idx;
  logic [efws_pkg::AddrW-1:0]      left_addr;
  logic [efws_pkg::AddrW-1:0]      right_addr;
  logic                            left_in_heap;
  logic                            right_in_heap;
  logic [efws_pkg::TimeW:0]        sum_wide;
  logic [efws_pkg::TimeW-1:0]      sum_sat;
  logic                            accept;

  logic                            ram_we;
  logic [efws_pkg::AddrW-1:0]      ram_waddr;
  efws_pkg::key_t                  ram_wdata;
  efws_pkg::key_t                  ram_rdata_a;
  efws_pkg::key_t                  ram_rdata_b;
  efws_pkg::key_t                  left_key;
  efws_pkg::key_t                  right_key;
  efws_pkg::sel_t                  sel;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // A count of zero behaves as one worker; anything above the heap size is clipped.
  always_comb begin
    logic [31:0] act;
    act = 32'(active_workers_q);
    if (act == 32'd0) begin
      heap_count = efws_pkg::ChildW'(1);
    end else if (act > 32'(efws_pkg::MaxWorkers)) begin
      heap_count = efws_pkg::ChildW'(efws_pkg::MaxWorkers);
    end else begin
      heap_count = efws_pkg::ChildW'(act);
    end
  end

  assign left_idx      = efws_pkg::ChildW'({pos_q, 1'b1});
  assign right_idx     = left_idx + efws_pkg::ChildW'(1);
  assign left_addr     = left_idx[efws_pkg::AddrW-1:0];
  assign right_addr    = right_idx[efws_pkg::AddrW-1:0];
  assign left_in_heap  = left_idx < heap_count;
  assign right_in_heap = right_idx < heap_count;

  // Saturating update of the root's free time.
  assign sum_wide = {1'b0, root_q.free_time} + (efws_pkg::TimeW + 1)'(job_duration_i);
  assign sum_sat  = sum_wide[efws_pkg::TimeW] ? {efws_pkg::TimeW{1'b1}}
                                              : sum_wide[efws_pkg::TimeW-1:0];

  // Slots never written since the last refill hold free time zero and their own
  // slot number as the worker.
  assign left_key  = left_valid_q ? ram_rdata_a
                                  : {{efws_pkg::TimeW{1'b0}}, efws_pkg::WorkerW'(left_addr)};
  assign right_key = right_valid_q ? ram_rdata_b
                                   : {{efws_pkg::TimeW{1'b0}}, efws_pkg::WorkerW'(right_addr)};

  efws_ram #(
    .Width ($bits(efws_pkg::key_t)),
    .Depth (efws_pkg::MaxWorkers)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (left_addr),
    .raddr_b_i (right_addr),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  efws_sel u_sel (
    .right_ok_i (right_in_heap),
    .elem_i     (elem_q),
    .left_i     (left_key),
    .right_i    (right_key),
    .sel_o      (sel)
  );

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    elem_d    = elem_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = elem_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          elem_d.free_time = sum_sat;
          elem_d.worker    = root_q.worker;
          pos_d            = '0;
          state_d          = StRead;
        end
      end
      StRead: begin
        // A slot with no children is where the moving element settles.
        if (!left_in_heap) begin
          ram_we  = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        ram_we    = 1'b1;
        ram_wdata = sel.best;
        unique case (sel.pick)
          efws_pkg::PickLeft: begin
            pos_d   = left_addr;
            state_d = StRead;
          end
          efws_pkg::PickRight: begin
            pos_d   = right_addr;
            state_d = StRead;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      pos_q            <= '0;
      root_q           <= '0;
      active_workers_q <= efws_pkg::CfgW'(efws_pkg::MaxWorkers);
      valid_q          <= '0;
      done_q           <= 1'b0;
    end else if (cfg_we_i) begin
      // A new worker count empties the heap back to its initial order.
      state_q          <= StIdle;
      pos_q            <= '0;
      root_q           <= '0;
      active_workers_q <= cfg_wdata_i;
      valid_q          <= '0;
      done_q           <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      done_q  <= accept;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
        if (ram_waddr == '0) begin
          root_q <= ram_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q        <= elem_d;
    left_valid_q  <= valid_q[left_addr];
    right_valid_q <= valid_q[right_addr];
    if (accept) begin
      worker_id_q  <= efws_pkg::WorkerIdW'(root_q.worker);
      start_time_q <= root_q.free_time;
    end
  end

  assign done_o       = done_q;
  assign worker_id_o  = worker_id_q;
  assign start_time_o = start_time_q;

`ifndef SYNTH
  // The heap RAM is only written while a transaction is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> busy)
    else $error("heap written while idle");

  // Every result follows an accepted transaction in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> $past(start && !busy))
    else $error("result without an accepted transaction");

  // The compare cycle always follows a child read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StCmp) |-> $past(state_q == StRead))
    else $error("compare without a preceding read");

  // The sift position never leaves the live part of the heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy |-> (efws_pkg::ChildW'(pos_q) < heap_count))
    else $error("sift position beyond heap");
`endif

endmodule
`default_nettype wire
